@@ rtl/core/hbp_pkg.sv @@
// ----------------------------------------------------------------------------
// hbp_pkg: shared types and constants of the Huffman bit packer
// Opcodes, table entry layout and the helper that builds a table entry.
// ----------------------------------------------------------------------------
`default_nettype none

package hbp_pkg;

	localparam int SYMBOL_BITS     = 8;
	localparam int MAX_CODE_LENGTH = 24;
	localparam int CODE_BITS       = 24;
	localparam int LEN_BITS        = 5;
	localparam int WORD_BITS       = 32;
	localparam int FILL_BITS       = 5;
	localparam int TABLE_DEPTH     = 1 << SYMBOL_BITS;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_e_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] code;
		logic [LEN_BITS-1:0]  len;
	} entry_t;

	// Handoff from the input side to the packing stage.
	typedef struct packed {
		logic      valid;
		opcode_e_t op;
	} req_t;

	// Saturates the length and clears code bits below it.
	function automatic entry_t make_entry(input logic [CODE_BITS-1:0] bits,
			input logic [LEN_BITS-1:0] len_in);
		entry_t              e;
		logic [LEN_BITS-1:0] len;
		len = len_in;
		if (len > LEN_BITS'(MAX_CODE_LENGTH)) begin
			len = LEN_BITS'(MAX_CODE_LENGTH);
		end
		e.len  = len;
		e.code = bits & ~({CODE_BITS{1'b1}} >> len);
		return e;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/huffman_bit_packer.sv @@
// ----------------------------------------------------------------------------
// huffman_bit_packer: table-driven Huffman encoder with 32-bit word packing
// Loads a 256-entry code table and packs codes MSB-first into words.
// ----------------------------------------------------------------------------
// The block takes one input word per clock cycle while s_tready is high, and
// registers a packed word once an input word completes it. An input word is a
// load, an encode or a flush, selected by s_tuser. A load writes one entry of
// the code table; lengths above 24 are saturated to 24 and code bits below the
// length are stored as zero. An encode looks up its symbol in the table during
// the accept cycle and then merges the code just below the bits
// already held; when 32 bits are full the word is sent with m_tuser low and the
// remaining code bits start the next word. A flush sends the partial word, if
// any bits are held, with m_tuser high, and clears the accumulator. Encoding a
// symbol whose table entry was never loaded gives an undefined word. The rate
// is set by the accumulator update, one shift and OR per cycle, and by the
// single table address, which serves either one load or one encode per cycle.
// The block stalls its input only while a finished word waits at the output
// and the item in the packing stage cannot move. The table has no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_bit_packer
	import hbp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// s_tdata, low bit up: symbol[7:0], code_bits[31:8], code_length[36:32],
	// zero padding[39:37]
	input  wire logic [39:0] s_tdata,
	// s_tuser: opcode[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// m_tdata: packed_word[31:0]
	output logic [31:0]      m_tdata,
	// m_tuser: is_flush_word[0]
	output logic [0:0]       m_tuser
);

	logic                    accept;
	opcode_e_t               op;
	logic [SYMBOL_BITS-1:0]  symbol;
	entry_t                  load_entry;
	entry_t                  rd_entry;
	req_t                    req;
	logic                    pack_ready;

	assign s_tready = pack_ready;
	assign accept   = s_tvalid && s_tready;
	assign op       = opcode_e_t'(s_tuser);
	assign symbol   = s_tdata[SYMBOL_BITS-1:0];

	// Table entry as it will be stored, built straight from the input word.
	assign load_entry = make_entry(s_tdata[31:8], s_tdata[36:32]);

	assign req.valid = accept;
	assign req.op    = op;

	hbp_table u_table (
		.clk     (clk),
		.wr_en   (accept && op == OP_LOAD),
		.rd_en   (accept && op == OP_ENCODE),
		.addr    (symbol),
		.wr_data (load_entry),
		.rd_data (rd_entry)
	);

	hbp_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.entry     (rd_entry),
		.ready     (pack_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (m_tdata),
		.out_flush (m_tuser[0])
	);

endmodule

`default_nettype wire

@@ rtl/core/hbp_table.sv @@
// ----------------------------------------------------------------------------
// hbp_table: code table memory
// One write port for loads, one registered read port for encodes.
// ----------------------------------------------------------------------------
`default_nettype none

module hbp_table
	import hbp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   wr_en,
	input  wire logic                   rd_en,
	input  wire logic [SYMBOL_BITS-1:0] addr,
	input  wire entry_t                 wr_data,
	output entry_t                      rd_data
);

	entry_t mem [TABLE_DEPTH];

	// A load and an encode never share an edge, so the read always sees
	// every earlier load without forwarding.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/hbp_pack.sv @@
// ----------------------------------------------------------------------------
// hbp_pack: accumulator stage and output register
// Merges each looked-up code into the accumulator and emits full words.
// ----------------------------------------------------------------------------
`default_nettype none

module hbp_pack
	import hbp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire req_t                 req,
	input  wire entry_t               entry,
	output logic                      ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [WORD_BITS-1:0]      out_word,
	output logic                      out_flush
);

	logic                   valid_s1;
	opcode_e_t              op_s1;
	logic [WORD_BITS-1:0]   acc_q;
	logic [FILL_BITS-1:0]   fill_q;
	logic                   out_valid_q;
	logic [WORD_BITS-1:0]   out_word_q;
	logic                   out_flush_q;

	logic                   out_hold;
	logic                   fire;
	logic [2*WORD_BITS-1:0] shifted;
	logic [WORD_BITS-1:0]   acc_or;
	logic [FILL_BITS:0]     total;
	logic                   emit;
	logic                   emit_flag;

	assign out_hold = out_valid_q && !out_ready;
	assign fire     = valid_s1 && !out_hold;
	assign ready    = !valid_s1 || !out_hold;

	// Upper half lands under the held bits, lower half is the carry-over.
	assign shifted = {entry.code, {(2*WORD_BITS-CODE_BITS){1'b0}}} >> fill_q;
	assign acc_or  = acc_q | shifted[2*WORD_BITS-1:WORD_BITS];
	assign total   = {1'b0, fill_q} + {1'b0, entry.len};

	always_comb begin
		emit      = 1'b0;
		emit_flag = 1'b0;
		unique case (op_s1)
			OP_ENCODE: emit = total[FILL_BITS];
			OP_FLUSH: begin
				emit      = fill_q != '0;
				emit_flag = 1'b1;
			end
			OP_LOAD, OP_NONE: emit = 1'b0;
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			op_s1       <= OP_NONE;
			acc_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.valid) begin
				valid_s1 <= 1'b1;
				op_s1    <= req.op;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end

			if (fire && op_s1 == OP_ENCODE) begin
				if (total[FILL_BITS]) begin
					acc_q <= shifted[WORD_BITS-1:0];
				end else begin
					acc_q <= acc_or;
				end
				fill_q <= total[FILL_BITS-1:0];
			end else if (fire && op_s1 == OP_FLUSH) begin
				acc_q  <= '0;
				fill_q <= '0;
			end

			if (fire && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_word_q  <= (op_s1 == OP_FLUSH) ? acc_q : acc_or;
			out_flush_q <= emit_flag;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_flush = out_flush_q;

endmodule

`default_nettype wire

@@ rtl/core/hbp_checker.sv @@
// ----------------------------------------------------------------------------
// hbp_checker: port checks for the Huffman bit packer
// Watches the stream ports and flags ordering and stall slips.
// ----------------------------------------------------------------------------
`default_nettype none

module hbp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [0:0]  m_tuser
);

	// A waiting word holds still until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	// The input is held off only behind a stalled output word.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a waiting output word");

	// A fresh word follows an accepted input word through the packing stage and output register.
	a_word_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("output word without a matching input word");

endmodule

bind huffman_bit_packer hbp_checker u_hbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
